[design/plfr_pkg.sv]
// ----------------------------------------------------------------------------
// plfr_pkg
// Shared types, codes and the CRC step of the parameter load frame receiver.
// ----------------------------------------------------------------------------
package plfr_pkg;

  // Result kinds as seen on the result ports
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_SAVE  = 2'd1;
  localparam logic [1:0] KIND_REPLY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOAD_CMD = 2'd0;
  localparam logic [1:0] CFG_SAVE_CMD = 2'd1;
  localparam logic [1:0] CFG_ACK_BYTE = 2'd2;

  localparam logic [7:0] LOAD_CMD_RESET = 8'd1;
  localparam logic [7:0] SAVE_CMD_RESET = 8'd2;
  localparam logic [7:0] ACK_BYTE_RESET = 8'd0;

  // Second byte of every reply: number of code bytes that follow
  localparam logic [7:0] REPLY_CODE_LEN = 8'd2;
  localparam logic [2:0] REPLY_LAST_BEAT = 3'd5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  // Work request handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [31:0] value;
    logic [7:0]  ack;
    logic [15:0] code;
    logic [15:0] crc;
  } cmd_t;

  // One byte of CRC-16/CCITT-FALSE (poly 0x1021), table-free form
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [7:0] x;
    x = crc[15:8] ^ data;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

endpackage

[design/plfr_front.sv]
// ----------------------------------------------------------------------------
// plfr_front
// Frame parser: walks the command frame one byte at a time and issues
// parameter write, save and reply requests.
// ----------------------------------------------------------------------------
module plfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              byte_valid_i,
  input  logic [7:0]        rx_byte_i,
  output logic              req_valid_o,
  output plfr_pkg::cmd_t    req_o
);
  import plfr_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CODE_MSB = 3'd1;
  localparam logic [2:0] PH_CODE_LSB = 3'd2;
  localparam logic [2:0] PH_COUNT    = 3'd3;
  localparam logic [2:0] PH_DATA     = 3'd4;
  localparam logic [2:0] PH_CRC1     = 3'd5;
  localparam logic [2:0] PH_CRC2     = 3'd6;

  logic [7:0]  load_cmd_q, save_cmd_q, ack_q;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] code_q, code_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  index_q, index_d;
  logic [1:0]  nbyte_q, nbyte_d;
  logic [23:0] acc_q, acc_d;
  logic [15:0] crc;

  assign crc = crc_byte(crc_byte(CRC_INIT, code_q[15:8]), code_q[7:0]);

  always_comb begin
    phase_d     = phase_q;
    code_d      = code_q;
    count_d     = count_q;
    index_d     = index_q;
    nbyte_d     = nbyte_q;
    acc_d       = acc_q;
    req_valid_o = 1'b0;
    req_o       = '0;
    req_o.ack   = ack_q;
    req_o.code  = code_q;
    req_o.crc   = crc;
    req_o.addr  = code_q + {8'd0, index_q};
    req_o.value = {acc_q, rx_byte_i};
    if (byte_valid_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == save_cmd_q) begin
            req_valid_o = 1'b1;
            req_o.kind  = KIND_SAVE;
          end else if (rx_byte_i == load_cmd_q) begin
            phase_d = PH_CODE_MSB;
          end
        end
        PH_CODE_MSB: begin
          code_d  = {rx_byte_i, 8'd0};
          phase_d = PH_CODE_LSB;
        end
        PH_CODE_LSB: begin
          code_d  = {code_q[15:8], rx_byte_i};
          phase_d = PH_COUNT;
        end
        PH_COUNT: begin
          count_d = rx_byte_i;
          index_d = '0;
          nbyte_d = '0;
          acc_d   = '0;
          phase_d = (rx_byte_i == 8'd0) ? PH_CRC1 : PH_DATA;
        end
        PH_DATA: begin
          if (nbyte_q != 2'd3) begin
            acc_d   = {acc_q[15:0], rx_byte_i};
            nbyte_d = nbyte_q + 2'd1;
          end else begin
            req_valid_o = 1'b1;
            req_o.kind  = KIND_WRITE;
            index_d     = index_q + 8'd1;
            nbyte_d     = '0;
            acc_d       = '0;
            if (index_d == count_q) phase_d = PH_CRC1;
          end
        end
        PH_CRC1: phase_d = PH_CRC2;
        PH_CRC2: begin
          req_valid_o = 1'b1;
          req_o.kind  = KIND_REPLY;
          phase_d     = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      code_q     <= '0;
      count_q    <= '0;
      index_q    <= '0;
      nbyte_q    <= '0;
      acc_q      <= '0;
      load_cmd_q <= LOAD_CMD_RESET;
      save_cmd_q <= SAVE_CMD_RESET;
      ack_q      <= ACK_BYTE_RESET;
    end else begin
      phase_q <= phase_d;
      code_q  <= code_d;
      count_q <= count_d;
      index_q <= index_d;
      nbyte_q <= nbyte_d;
      acc_q   <= acc_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_LOAD_CMD: load_cmd_q <= cfg_data_i;
          CFG_SAVE_CMD: save_cmd_q <= cfg_data_i;
          CFG_ACK_BYTE: ack_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[design/plfr_queue.sv]
// ----------------------------------------------------------------------------
// plfr_queue
// Short request queue between the frame parser and the result sequencer.
// ----------------------------------------------------------------------------
module plfr_queue #(
  parameter int unsigned Depth = plfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  plfr_pkg::cmd_t    data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output plfr_pkg::cmd_t    data_o
);
  import plfr_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[design/plfr_back.sv]
// ----------------------------------------------------------------------------
// plfr_back
// Result sequencer: expands queued requests into result items and holds
// them in the output register.
// ----------------------------------------------------------------------------
module plfr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_empty_i,
  input  plfr_pkg::cmd_t     req_i,
  output logic               req_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic [15:0]        param_address_o,
  output logic signed [31:0] param_value_o,
  output logic [7:0]         reply_byte_o,
  output logic               last_o
);
  import plfr_pkg::*;

  logic        out_valid_q;
  logic        load;
  logic [2:0]  beat_q, beat_d;
  logic [1:0]  kind_d;
  logic [15:0] addr_d;
  logic [31:0] value_d;
  logic [7:0]  rb_d;
  logic        last_d;

  assign empty = !out_valid_q;
  // Refill the output register when it is free or being drained this cycle
  assign load  = (!out_valid_q || pop) && !req_empty_i;

  always_comb begin
    beat_d    = beat_q;
    req_pop_o = 1'b0;
    kind_d    = req_i.kind;
    addr_d    = '0;
    value_d   = '0;
    rb_d      = '0;
    last_d    = 1'b1;
    case (req_i.kind)
      KIND_WRITE: begin
        addr_d  = req_i.addr;
        value_d = req_i.value;
      end
      KIND_REPLY: begin
        case (beat_q)
          3'd0:    rb_d = req_i.ack;
          3'd1:    rb_d = REPLY_CODE_LEN;
          3'd2:    rb_d = req_i.code[15:8];
          3'd3:    rb_d = req_i.code[7:0];
          3'd4:    rb_d = req_i.crc[15:8];
          default: rb_d = req_i.crc[7:0];
        endcase
        last_d = (beat_q == REPLY_LAST_BEAT);
      end
      default: ;
    endcase
    if (load) begin
      if (last_d) begin
        req_pop_o = 1'b1;
        beat_d    = '0;
      end else begin
        beat_d = beat_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= '0;
    end else begin
      beat_q <= beat_d;
      if (load)     out_valid_q <= 1'b1;
      else if (pop) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o          <= kind_d;
      param_address_o <= addr_d;
      param_value_o   <= signed'(value_d);
      reply_byte_o    <= rb_d;
      last_o          <= last_d;
    end
  end

endmodule

[design/param_load_frame_receiver_unit.sv]
// ----------------------------------------------------------------------------
// param_load_frame_receiver_unit
// Receives parameter load frames byte by byte and issues parameter writes,
// save requests and the reply frame.
// ----------------------------------------------------------------------------
// Bytes are pushed in through a queue-style port (push/full) and results
// are popped from a queue-style port (empty/pop). A byte is taken every clock
// while full is low; the frame parser handles it in the cycle it arrives.
// A parameter write or a save request becomes one result; the second CRC
// byte of a load frame becomes six reply results (ack, 2, code MSB, code
// LSB, CRC MSB, CRC LSB), delivered one per cycle from the output register
// while the consumer keeps popping, so the result side sets the pace. A
// request queue of QueueDepth entries lets the parser keep taking bytes
// while the sequencer drains a reply or the consumer stalls; full rises
// only when that queue fills. The last result caused by one byte carries
// last_o. Configuration (load command, save command, ack byte) is to be
// written through cfg_we_i/cfg_index_i/cfg_data_i only while the block is
// idle; the block does not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module param_load_frame_receiver_unit #(
  parameter int unsigned QueueDepth = plfr_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // byte input
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic [15:0]        param_address_o,
  output logic signed [31:0] param_value_o,
  output logic [7:0]         reply_byte_o,
  output logic               last_o
);
  import plfr_pkg::*;

  logic accept;
  logic req_valid;
  cmd_t req;
  logic q_empty;
  cmd_t q_head;
  logic q_pop;

  // Take a byte whenever the request queue has room for what it may cause
  assign accept = push && !full;

  plfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (accept),
    .rx_byte_i    (rx_byte_i),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  // Hold requests until the sequencer is ready for them
  plfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_valid),
    .data_i  (req),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  // Expand requests into result items
  plfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_empty_i     (q_empty),
    .req_i           (q_head),
    .req_pop_o       (q_pop),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind_o),
    .param_address_o (param_address_o),
    .param_value_o   (param_value_o),
    .reply_byte_o    (reply_byte_o),
    .last_o          (last_o)
  );

endmodule
